[sv/psgd_pkg.sv]
// Package for per-source pulse gap and damage statistics.
// Beat types, sizes and read codes; no dependencies.
`default_nettype none
package psgd_pkg;
	localparam int NumSources = 32;
	localparam int NumBins    = 32;
	localparam int DamageBits = 32;
	localparam logic [16:0] MaxPulse = 17'd131040;
	localparam logic [5:0]  ZeroBin  = 6'd13;

	localparam logic [1:0] KIND_EVENTS = 2'd0;
	localparam logic [1:0] KIND_MASK   = 2'd1;
	localparam logic [1:0] KIND_DBIT   = 2'd2;
	localparam logic [1:0] KIND_HIST   = 2'd3;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [4:0]  source_id;
		logic [16:0] pulse_id;
		logic [31:0] damage_word;
		logic [1:0]  read_kind;
		logic [4:0]  read_index;
	} in_beat_t;

	typedef struct packed {
		logic        bad_pulse;
		logic        hist_updated;
		logic [4:0]  hist_bin;
		logic [31:0] read_value;
	} out_beat_t;
endpackage
`default_nettype wire

[sv/psgd_src_ram.sv]
// Per-source record memory: event count, mask, last pulse, valid bit.
// Uses psgd_pkg. Registered read.
`default_nettype none
module psgd_src_ram import psgd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [4:0]  waddr,
	input  wire logic [81:0] wdata,
	input  wire logic [4:0]  raddr,
	output logic      [81:0] rdata
);
	logic [81:0] mem [NumSources];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/psgd_row_ram.sv]
// Row memory: one row of 32 counters per source, per-counter write enables.
// Uses psgd_pkg. Registered read.
`default_nettype none
module psgd_row_ram import psgd_pkg::*; (
	input  wire logic              clk,
	input  wire logic [31:0]       we,
	input  wire logic [4:0]        waddr,
	input  wire logic [32*32-1:0]  wdata,
	input  wire logic [4:0]        raddr,
	output logic      [32*32-1:0]  rdata
);
	logic [32*32-1:0] mem [NumSources];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 32; i++)
			if (we[i]) mem[waddr][i*32 +: 32] <= wdata[i*32 +: 32];
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/per_source_pulse_gap_and_damage_stats.sv]
// Top level: per-source pulse gap histogram and damage statistics.
// Uses psgd_pkg, psgd_src_ram, psgd_row_ram.
//
//  beat     ports              handshake
//  ------   ----------------   ---------------------------
//  command  start, cmd_in      taken when start && !busy
//  result   done, res          one cycle, strobe done
//
// Each beat reads the memories when it is taken; the write back and the
// result follow from the registered read data while act_s1 is high, and
// busy is high with it. No stall on results. After reset the memories
// hold garbage; a sweep clears all 32 source rows (busy high throughout),
// and a beat is first taken once the sweep is over.
`default_nettype none
module per_source_pulse_gap_and_damage_stats import psgd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire in_beat_t  cmd_in,
	output logic           busy,
	output logic           done,
	output out_beat_t      res
);
	// sweep counter: clearing pass after reset
	logic [5:0] clr_q;
	logic       clearing;
	assign clearing = !clr_q[5];

	logic     act_s1;
	in_beat_t beat_s1;
	logic     take;
	assign take = start && !busy;
	assign busy = clearing || act_s1;
	// result is formed from the registered memory read data
	assign done = act_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			act_s1 <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 6'd1;
			act_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) beat_s1 <= cmd_in;
	end

	// memories
	logic [81:0]      src_rd, src_wd;
	logic [1023:0]    dmg_rd, dmg_wd, hist_rd, hist_wd;
	logic [31:0]      dmg_we, hist_we;
	logic             src_we;
	logic [4:0]       waddr;

	psgd_src_ram u_src (.clk, .we(src_we), .waddr, .wdata(src_wd),
		.raddr(cmd_in.source_id), .rdata(src_rd));
	psgd_row_ram u_dmg (.clk, .we(dmg_we), .waddr, .wdata(dmg_wd),
		.raddr(cmd_in.source_id), .rdata(dmg_rd));
	psgd_row_ram u_hist (.clk, .we(hist_we), .waddr, .wdata(hist_wd),
		.raddr(cmd_in.source_id), .rdata(hist_rd));

	// source row fields: [81:50] events, [49:18] mask, [17:1] last, [0] valid
	logic [31:0] ev, mk;
	logic [16:0] last;
	logic        lv;
	assign ev   = src_rd[81:50];
	assign mk   = src_rd[49:18];
	assign last = src_rd[17:1];
	assign lv   = src_rd[0];

	logic        rec, bad, upd;
	logic [17:0] gap;
	logic [17:0] ix;
	logic [4:0]  bin;
	always_comb begin
		rec = act_s1 && beat_s1.cmd == CMD_RECORD;
		bad = beat_s1.pulse_id >= MaxPulse;
		// gap modulo MaxPulse
		if (beat_s1.pulse_id >= last)
			gap = {1'b0, beat_s1.pulse_id} - {1'b0, last};
		else
			gap = {1'b0, beat_s1.pulse_id} + {1'b0, MaxPulse} - {1'b0, last};
		ix  = gap + {12'd0, ZeroBin};
		bin = (ix >= 18'(NumBins)) ? 5'(NumBins - 1) : ix[4:0];
		upd = rec && !bad && lv;
	end

	always_comb begin
		waddr   = clearing ? clr_q[4:0] : beat_s1.source_id;
		src_we  = clearing || rec;
		src_wd  = '0;
		dmg_we  = clearing ? '1 : '0;
		hist_we = clearing ? '1 : '0;
		dmg_wd  = '0;
		hist_wd = '0;
		if (!clearing && rec) begin
			src_wd[81:50] = ev + 32'd1;
			src_wd[49:18] = mk | beat_s1.damage_word;
			src_wd[17:0]  = bad ? src_rd[17:0] : {beat_s1.pulse_id, 1'b1};
			dmg_we = beat_s1.damage_word;
			for (int i = 0; i < DamageBits; i++)
				dmg_wd[i*32 +: 32] = dmg_rd[i*32 +: 32] + 32'd1;
			hist_wd[bin*32 +: 32] = hist_rd[bin*32 +: 32] + 32'd1;
			if (upd) hist_we[bin] = 1'b1;
		end
	end

	always_comb begin
		res = '0;
		if (act_s1) begin
			if (beat_s1.cmd == CMD_READ) begin
				case (beat_s1.read_kind)
					KIND_EVENTS: res.read_value = ev;
					KIND_MASK:   res.read_value = mk;
					KIND_DBIT:   res.read_value = dmg_rd[beat_s1.read_index*32 +: 32];
					KIND_HIST:   res.read_value = hist_rd[beat_s1.read_index*32 +: 32];
					default:     res.read_value = '0;
				endcase
			end else begin
				res.bad_pulse    = bad;
				res.hist_updated = upd;
				res.hist_bin     = upd ? bin : 5'd0;
			end
		end
	end
endmodule
`default_nettype wire

[sv/psgd_checker.sv]
// Port checker for the statistics block, bound to the top level.
// Uses psgd_pkg.
`default_nettype none
module psgd_checker import psgd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire out_beat_t res
);
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##1 done) else $error("missing result");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> res == '0) else $error("result without strobe");
	a_bin_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.hist_updated |-> res.hist_bin == 5'd0) else $error("stray bin");
endmodule

bind per_source_pulse_gap_and_damage_stats psgd_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .res);
`default_nettype wire
